// File: rtl/quadratic_adc_nonlinearity_correction_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ADC nonlinearity correction unit
// Shared property templates, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ADC_NONLINEARITY_CORRECTION_UNIT_DEFINES_SVH
`define QUADRATIC_ADC_NONLINEARITY_CORRECTION_UNIT_DEFINES_SVH

// same-cycle implication
`define QANC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QANC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/qanc_pkg.sv
// ----------------------------------------------------------------------------
// qanc_pkg
// Constants and codes of the quadratic ADC nonlinearity correction unit.
// ----------------------------------------------------------------------------
package qanc_pkg;

	localparam int CHANNELS  = 2048;
	localparam int ADDR_W    = $clog2(CHANNELS);
	localparam int CH_W      = 11;
	localparam int SQ_STEPS  = 34;
	localparam int DIV_STEPS = 41;
	localparam int IN_W      = 128;
	localparam int OUT_W     = 40;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CORR = 1'b1;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_NEG = 2'd1;
	localparam logic [1:0] STAT_SAT = 2'd2;

	typedef struct packed {
		logic               azero;
		logic               negd;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [15:0] s;
	} ctx_t;

endpackage

// File: rtl/quadratic_adc_nonlinearity_correction_unit.sv
// ----------------------------------------------------------------------------
// quadratic_adc_nonlinearity_correction_unit
// Per-channel ADC linearity correction: inverts a*x^2+b*x+c and returns b*x+c.
// ----------------------------------------------------------------------------
// channel | dir | signals                         | content
// s_      | in  | tvalid tready tdata[127:0] tuser | load or correct item
// m_      | out | tvalid tready tdata[39:0]        | corrected value, status
//
// One item per cycle while m_ is not stalled.
// Depth set by the 34-step square root and the 41-step divider pipelines.
// Loads write the coefficient RAM and yield no result.
// Reset clears valid bits only; coefficient RAM is undefined until loaded.
// A stall on m_ freezes the whole pipeline; s_tready drops with it.
// ----------------------------------------------------------------------------
`include "quadratic_adc_nonlinearity_correction_unit_defines.svh"

module quadratic_adc_nonlinearity_correction_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// channel[10:0], adc_sample[26:11], quad_coef[58:27], slope_coef[90:59],
	// offset_coef[122:91], zero fill
	input  logic [qanc_pkg::IN_W-1:0]   s_tdata,
	// operation[0]
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// corrected[31:0], status[33:32], zero fill
	output logic [qanc_pkg::OUT_W-1:0]  m_tdata
);

	localparam int NSQ = qanc_pkg::SQ_STEPS;
	localparam int NDV = qanc_pkg::DIV_STEPS;

	logic en;
	logic in_xfer;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign in_xfer  = s_tvalid && s_tready;

	logic [qanc_pkg::CH_W-1:0] in_ch;
	logic signed [15:0]        in_s;
	logic                      in_ok;
	assign in_ch = s_tdata[10:0];
	assign in_s  = s_tdata[26:11];
	assign in_ok = 32'(in_ch) < 32'(qanc_pkg::CHANNELS);

	// coefficient RAM {c, b, a}
	logic [95:0] mem [qanc_pkg::CHANNELS];
	logic [95:0] rd_s1;

	always_ff @(posedge clk) begin
		if (in_xfer && s_tuser == qanc_pkg::OP_LOAD && in_ok)
			mem[in_ch[qanc_pkg::ADDR_W-1:0]] <= {s_tdata[122:91], s_tdata[90:59], s_tdata[58:27]};
		if (en)
			rd_s1 <= mem[in_ch[qanc_pkg::ADDR_W-1:0]];
	end

	// stage 1
	logic               v_s1, ok_s1;
	logic signed [15:0] s_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_xfer && s_tuser == qanc_pkg::OP_CORR;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= in_ok;
			s_s1  <= in_s;
		end
	end

	// stage 2: coefficients, residual e = c - 256*s, magnitudes
	logic signed [31:0] a1, b1, c1;
	logic signed [32:0] e1;
	logic [32:0]        ne1;
	assign a1  = ok_s1 ? signed'(rd_s1[31:0])  : 32'sd0;
	assign b1  = ok_s1 ? signed'(rd_s1[63:32]) : 32'sd0;
	assign c1  = ok_s1 ? signed'(rd_s1[95:64]) : 32'sd0;
	assign e1  = {c1[31], c1} - {{9{s_s1[15]}}, s_s1, 8'h00};
	assign ne1 = -e1;

	logic               v_s2, aeneg_s2;
	qanc_pkg::ctx_t     ctx_s2;
	logic [31:0]        maga_s2, mage_s2, magb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2.azero <= a1 == 32'sd0;
			ctx_s2.negd  <= 1'b0;
			ctx_s2.a     <= a1;
			ctx_s2.b     <= b1;
			ctx_s2.c     <= c1;
			ctx_s2.s     <= s_s1;
			maga_s2      <= a1[31] ? 32'(-a1) : 32'(a1);
			magb_s2      <= b1[31] ? 32'(-b1) : 32'(b1);
			mage_s2      <= e1[32] ? ne1[31:0] : e1[31:0];
			aeneg_s2     <= (e1 != 33'sd0) && (a1[31] != e1[32]);
		end
	end

	// stage 3: products
	logic           v_s3, aeneg_s3;
	qanc_pkg::ctx_t ctx_s3;
	logic [63:0]    mae_s3, bb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3   <= ctx_s2;
			aeneg_s3 <= aeneg_s2;
			mae_s3   <= maga_s2 * mage_s2;
			bb_s3    <= magb_s2 * magb_s2;
		end
	end

	// stage 4: discriminant
	logic [65:0] m4_3, p_3;
	assign m4_3 = {mae_s3, 2'b00};
	assign p_3  = {2'b00, bb_s3};

	qanc_pkg::ctx_t ctx_3;
	always_comb begin
		ctx_3      = ctx_s3;
		ctx_3.negd = !aeneg_s3 && (m4_3 > p_3);
	end

	logic           v_s4;
	qanc_pkg::ctx_t ctx_s4;
	logic [65:0]    d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_3;
			d_s4   <= aeneg_s3 ? p_3 + m4_3 : p_3 - m4_3;
		end
	end

	// square root, one result bit per stage
	logic           sq_v    [NSQ+1];
	qanc_pkg::ctx_t sq_ctx  [NSQ+1];
	logic [67:0]    sq_rad  [NSQ+1];
	logic [36:0]    sq_rem  [NSQ+1];
	logic [33:0]    sq_root [NSQ+1];

	assign sq_v[0]    = v_s4;
	assign sq_ctx[0]  = ctx_s4;
	assign sq_rad[0]  = {2'b00, d_s4};
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		logic [36:0] rt, trial;
		logic        ge;
		assign rt    = {sq_rem[k][34:0], sq_rad[k][67:66]};
		assign trial = {1'b0, sq_root[k], 2'b01};
		assign ge    = rt >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (en) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_ctx[k+1]  <= sq_ctx[k];
				sq_rad[k+1]  <= {sq_rad[k][65:0], 2'b00};
				sq_rem[k+1]  <= ge ? rt - trial : rt;
				sq_root[k+1] <= {sq_root[k][32:0], ge};
			end
		end
	end

	// diff = r - b
	qanc_pkg::ctx_t     ctx_r;
	logic signed [34:0] diff_r;
	logic [34:0]        ndiff_r;
	assign ctx_r   = sq_ctx[NSQ];
	assign diff_r  = signed'({1'b0, sq_root[NSQ]}) - {{3{ctx_r.b[31]}}, ctx_r.b};
	assign ndiff_r = -diff_r;

	logic           v_sd, nneg_sd;
	qanc_pkg::ctx_t ctx_sd;
	logic [33:0]    magd_sd;
	logic [31:0]    magb_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (en) begin
			v_sd <= sq_v[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sd  <= ctx_r;
			magd_sd <= diff_r[34] ? ndiff_r[33:0] : diff_r[33:0];
			magb_sd <= ctx_r.b[31] ? 32'(-ctx_r.b) : 32'(ctx_r.b);
			nneg_sd <= (ctx_r.b != 32'sd0) && (diff_r != 35'sd0) && (ctx_r.b[31] != diff_r[34]);
		end
	end

	// numerator n = |b| * |diff|
	logic           v_sm, qneg_sm;
	qanc_pkg::ctx_t ctx_sm;
	logic [65:0]    n_sm;
	logic [32:0]    dv_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
		end else if (en) begin
			v_sm <= v_sd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sm  <= ctx_sd;
			n_sm    <= magb_sd * magd_sd;
			dv_sm   <= {(ctx_sd.a[31] ? 32'(-ctx_sd.a) : 32'(ctx_sd.a)), 1'b0};
			qneg_sm <= nneg_sd != ctx_sd.a[31];
		end
	end

	// quotient at or above 2^41 saturates outright
	logic presat_m;
	assign presat_m = {8'h00, n_sm[65:41]} >= dv_sm;

	logic           dv_v     [NDV+1];
	qanc_pkg::ctx_t dv_ctx   [NDV+1];
	logic [32:0]    dv_d     [NDV+1];
	logic [32:0]    dv_rem   [NDV+1];
	logic [40:0]    dv_num   [NDV+1];
	logic [40:0]    dv_q     [NDV+1];
	logic           dv_sat   [NDV+1];
	logic           dv_qneg  [NDV+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= v_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_ctx[0]  <= ctx_sm;
			dv_d[0]    <= dv_sm;
			dv_rem[0]  <= presat_m ? 33'd0 : {8'h00, n_sm[65:41]};
			dv_num[0]  <= n_sm[40:0];
			dv_q[0]    <= '0;
			dv_sat[0]  <= presat_m;
			dv_qneg[0] <= qneg_sm;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < NDV; k++) begin : g_dv
		logic [33:0] rt, sub;
		logic        ge;
		assign rt  = {dv_rem[k], dv_num[k][40]};
		assign sub = rt - {1'b0, dv_d[k]};
		assign ge  = rt >= {1'b0, dv_d[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (en) begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ctx[k+1]  <= dv_ctx[k];
				dv_d[k+1]    <= dv_d[k];
				dv_rem[k+1]  <= ge ? sub[32:0] : rt[32:0];
				dv_num[k+1]  <= {dv_num[k][39:0], 1'b0};
				dv_q[k+1]    <= {dv_q[k][39:0], ge};
				dv_sat[k+1]  <= dv_sat[k];
				dv_qneg[k+1] <= dv_qneg[k];
			end
		end
	end

	// final: sign, add offset, clamp
	qanc_pkg::ctx_t     ctx_f;
	logic [40:0]        q_f;
	logic signed [41:0] qs_f, y_f;
	logic               qsat_f;
	logic signed [31:0] res_f;
	logic [1:0]         st_f;

	assign ctx_f  = dv_ctx[NDV];
	assign q_f    = dv_q[NDV];
	assign qsat_f = dv_sat[NDV] || (q_f > 41'h100_0000_0000);
	assign qs_f   = dv_qneg[NDV] ? -signed'({1'b0, q_f}) : signed'({1'b0, q_f});
	assign y_f    = {{10{ctx_f.c[31]}}, ctx_f.c} + qs_f;

	always_comb begin
		res_f = 32'sd0;
		st_f  = qanc_pkg::STAT_OK;
		priority if (ctx_f.azero) begin
			res_f = {{8{ctx_f.s[15]}}, ctx_f.s, 8'h00};
		end else if (ctx_f.negd) begin
			st_f = qanc_pkg::STAT_NEG;
		end else if (qsat_f) begin
			res_f = dv_qneg[NDV] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			st_f  = qanc_pkg::STAT_SAT;
		end else if (y_f > 42'sh0_7fff_ffff) begin
			res_f = 32'sh7fff_ffff;
			st_f  = qanc_pkg::STAT_SAT;
		end else if (y_f < -42'sh0_8000_0000) begin
			res_f = 32'sh8000_0000;
			st_f  = qanc_pkg::STAT_SAT;
		end else begin
			res_f = y_f[31:0];
		end
	end

	logic                      out_v_q;
	logic [qanc_pkg::OUT_W-1:0] out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v[NDV];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			out_d_q <= {6'd0, st_f, res_f};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

	`QANC_ASSERT_NOW(a_neg_zero, m_tvalid && m_tdata[33:32] == qanc_pkg::STAT_NEG, m_tdata[31:0] == 32'd0, "negative discriminant with nonzero result")
	`QANC_ASSERT_NOW(a_stat_code, m_tvalid, m_tdata[33:32] != 2'd3, "undefined status code")
	`QANC_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed during stall")
	`QANC_ASSERT_NOW(a_zero_fill, m_tvalid, m_tdata[qanc_pkg::OUT_W-1:34] == 6'd0, "fill bits set")

endmodule
